[rtl/sssr_pkg.sv]
package sssr_pkg;

    localparam int MAX_ORDER   = 4096;
    localparam int MAX_FACTORS = 6;
    localparam int REG_FACTORS = 6;
    localparam int STORE_DEPTH = 4096;
    localparam int CODE_W      = 12;
    localparam int LEN_W       = 13;
    localparam int FACTOR_W    = 13;
    localparam int INDEX_W     = 3;

    localparam logic [INDEX_W-1:0] CFG_FACTOR_COUNT = 3'd0;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_ZERO     = 2'd1,
        ST_BAD_ELEM = 2'd2,
        ST_BAD_BASE = 2'd3
    } status_t;

    typedef struct packed {
        logic [CODE_W-1:0]   xa;
        logic [CODE_W-1:0]   xg;
        logic [FACTOR_W-1:0] f;
    } digit_in_t;

    typedef struct packed {
        logic [CODE_W-1:0] s_plus;
        logic [CODE_W-1:0] s_minus;
    } digit_out_t;

endpackage

[rtl/sssr_digit_alu.sv]
module sssr_digit_alu
    import sssr_pkg::*;
(
    input  digit_in_t  din,
    output digit_out_t dout
);

    logic [FACTOR_W:0]   sum_p;
    logic [FACTOR_W:0]   sum_m;
    logic [FACTOR_W-1:0] xg_neg;
    logic [FACTOR_W:0]   f_ext;

    always_comb begin
        f_ext  = {1'b0, din.f};
        // Negating a digit maps zero to zero and anything else to f minus it.
        xg_neg = (din.xg == '0) ? '0 : (din.f - {1'b0, din.xg});
        sum_p  = {2'b00, din.xa} + {2'b00, din.xg};
        sum_m  = {2'b00, din.xa} + {1'b0, xg_neg};
        if (sum_p >= f_ext) begin
            sum_p = sum_p - f_ext;
        end
        if (sum_m >= f_ext) begin
            sum_m = sum_m - f_ext;
        end
        dout.s_plus  = sum_p[CODE_W-1:0];
        dout.s_minus = sum_m[CODE_W-1:0];
    end

endmodule

[rtl/signed_subset_sum_reach_set_top.sv]
// Channel   Direction  Ports                                           Beat
// s_        in         s_valid s_ready s_mode s_element s_rollback_base one item
// m_        out        m_valid m_ready m_accepted m_previous_length     one result
//                      m_reach_length m_status
// cfg_      in         cfg_valid cfg_ready cfg_index cfg_data          one register write
//
// After reset the membership memory is swept clear entry by entry; s_ready stays low.
// An add runs the group check, splits the element into one digit per factor and inserts
// g and -g; then for each stored entry it makes one list read, a division through S_D0
// and S_D1 and one digit step per factor, and two read-modify-write passes on the member
// memory. A rejected add then clears its new entries, each with one read and one write.
// A rollback reads and clears the member bit of each removed entry in turn.
// A finished result waits in the output register while the next item is taken.
module signed_subset_sum_reach_set_top
    import sssr_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic                s_mode,
    input  logic [CODE_W-1:0]   s_element,
    input  logic [LEN_W-1:0]    s_rollback_base,
    output logic                m_valid,
    input  logic                m_ready,
    output logic                m_accepted,
    output logic [LEN_W-1:0]    m_previous_length,
    output logic [LEN_W-1:0]    m_reach_length,
    output logic [1:0]          m_status,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [INDEX_W-1:0]  cfg_index,
    input  logic [FACTOR_W-1:0] cfg_data
);

    typedef enum logic [12:0] {
        S_CLR    = 13'b0000000000001,
        S_IDLE   = 13'b0000000000010,
        S_ORDER  = 13'b0000000000100,
        S_D0     = 13'b0000000001000,
        S_D1     = 13'b0000000010000,
        S_ACC    = 13'b0000000100000,
        S_INS_RD = 13'b0000001000000,
        S_INS_WR = 13'b0000010000000,
        S_NEXT   = 13'b0000100000000,
        S_LOAD   = 13'b0001000000000,
        S_CUT_RD = 13'b0010000000000,
        S_CUT_WR = 13'b0100000000000,
        S_FIN    = 13'b1000000000000
    } state_t;

    typedef enum logic [1:0] {
        PH_G    = 2'd0,
        PH_SELF = 2'd1,
        PH_LIST = 2'd2
    } phase_t;

    state_t state_reg, state_next;
    phase_t phase_reg, phase_next;

    logic [INDEX_W-1:0]  fcount_reg;
    logic [FACTOR_W-1:0] factor_reg [REG_FACTORS];

    logic [INDEX_W-1:0]  k_reg, k_next;
    logic [LEN_W-1:0]    prod_reg, prod_next;
    logic                bad_reg, bad_next;
    logic [CODE_W-1:0]   g_reg, g_next;
    logic [CODE_W-1:0]   x_reg, x_next;
    logic [FACTOR_W-1:0] r_reg, r_next;
    logic [CODE_W-1:0]   q_reg, q_next;
    logic [CODE_W-1:0]   e1_reg, e1_next;
    logic [CODE_W-1:0]   e2_reg, e2_next;
    logic [CODE_W-1:0]   gd_reg [REG_FACTORS];
    logic [LEN_W-1:0]    w_reg  [REG_FACTORS];
    logic [LEN_W-1:0]    size_reg, size_next;
    logic [LEN_W-1:0]    before_reg, before_next;
    logic [LEN_W-1:0]    i_reg, i_next;
    logic [LEN_W-1:0]    j_reg, j_next;
    logic [LEN_W-1:0]    cut_base_reg, cut_base_next;
    logic                sel_reg, sel_next;
    status_t             status_reg, status_next;
    logic                acc_reg, acc_next;

    logic                m_valid_reg;
    logic                m_accepted_reg;
    logic [LEN_W-1:0]    m_prev_reg;
    logic [LEN_W-1:0]    m_len_reg;
    status_t             m_status_reg;

    logic                member_mem [STORE_DEPTH];
    logic [CODE_W-1:0]   list_mem   [STORE_DEPTH];
    logic                mem_q;
    logic [CODE_W-1:0]   list_q;

    logic                mem_we, mem_wd, list_we;
    logic [CODE_W-1:0]   mem_wa, mem_ra, list_wa, list_ra, list_wd;

    logic [FACTOR_W-1:0]   f_cur;
    logic [2*LEN_W-1:0]    prod_mul;
    logic [FACTOR_W-1:0]   div_r;
    logic [5:0]            div_q;
    logic [5:0]            div_bits;
    logic [CODE_W+LEN_W-1:0] term1, term2;
    logic [CODE_W-1:0]     ins_val;
    logic                  last_factor;
    logic                  fin_load;
    logic                  can_insert;
    digit_in_t             alu_in;
    digit_out_t            alu_out;

    assign s_ready   = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;

    assign m_valid           = m_valid_reg;
    assign m_accepted        = m_accepted_reg;
    assign m_previous_length = m_prev_reg;
    assign m_reach_length    = m_len_reg;
    assign m_status          = m_status_reg;

    assign f_cur       = (k_reg < INDEX_W'(REG_FACTORS)) ? factor_reg[k_reg] : FACTOR_W'(2);
    assign prod_mul    = prod_reg * {{(LEN_W-FACTOR_W){1'b0}}, f_cur};
    assign last_factor = (k_reg + 3'd1 == fcount_reg);
    assign ins_val     = sel_reg ? e2_reg : e1_reg;
    assign can_insert  = !mem_q && (size_reg < LEN_W'(STORE_DEPTH));
    assign fin_load    = (state_reg == S_FIN) && (!m_valid_reg || m_ready);

    // Restoring division, six quotient bits per cycle.
    always_comb begin
        logic [FACTOR_W-1:0] t;
        div_bits = (state_reg == S_D0) ? x_reg[11:6] : x_reg[5:0];
        div_r    = (state_reg == S_D0) ? '0 : r_reg;
        div_q    = '0;
        for (int b = 5; b >= 0; b--) begin
            t = {div_r[FACTOR_W-2:0], div_bits[b]};
            if (t >= f_cur) begin
                div_r    = t - f_cur;
                div_q[b] = 1'b1;
            end else begin
                div_r = t;
            end
        end
    end

    assign alu_in.xa = r_reg[CODE_W-1:0];
    assign alu_in.xg = (k_reg < INDEX_W'(REG_FACTORS)) ? gd_reg[k_reg] : '0;
    assign alu_in.f  = f_cur;

    sssr_digit_alu u_alu (
        .din  (alu_in),
        .dout (alu_out)
    );

    assign term1 = alu_out.s_plus  * ((k_reg < INDEX_W'(REG_FACTORS)) ? w_reg[k_reg] : '0);
    assign term2 = alu_out.s_minus * ((k_reg < INDEX_W'(REG_FACTORS)) ? w_reg[k_reg] : '0);

    always_comb begin
        state_next    = state_reg;
        phase_next    = phase_reg;
        k_next        = k_reg;
        prod_next     = prod_reg;
        bad_next      = bad_reg;
        g_next        = g_reg;
        x_next        = x_reg;
        r_next        = r_reg;
        q_next        = q_reg;
        e1_next       = e1_reg;
        e2_next       = e2_reg;
        size_next     = size_reg;
        before_next   = before_reg;
        i_next        = i_reg;
        j_next        = j_reg;
        cut_base_next = cut_base_reg;
        sel_next      = sel_reg;
        status_next   = status_reg;
        acc_next      = acc_reg;
        mem_we  = 1'b0;
        mem_wa  = j_reg[CODE_W-1:0];
        mem_wd  = 1'b0;
        mem_ra  = ins_val;
        list_we = 1'b0;
        list_wa = size_reg[CODE_W-1:0];
        list_wd = ins_val;
        list_ra = j_reg[CODE_W-1:0];

        unique case (state_reg)
            S_CLR: begin
                mem_we = 1'b1;
                j_next = j_reg + 13'd1;
                if (j_reg[CODE_W-1:0] == CODE_W'(STORE_DEPTH - 1)) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_valid) begin
                    before_next = size_reg;
                    g_next      = s_element;
                    if (s_mode) begin
                        if (s_rollback_base > size_reg) begin
                            status_next = ST_BAD_BASE;
                            acc_next    = 1'b0;
                            state_next  = S_FIN;
                        end else begin
                            cut_base_next = s_rollback_base;
                            j_next        = s_rollback_base;
                            status_next   = ST_OK;
                            acc_next      = 1'b1;
                            state_next    = S_CUT_RD;
                        end
                    end else begin
                        prod_next  = 13'd1;
                        k_next     = '0;
                        bad_next   = (fcount_reg == '0) ||
                                     (fcount_reg > INDEX_W'(MAX_FACTORS));
                        state_next = S_ORDER;
                    end
                end
            end
            S_ORDER: begin
                if (bad_reg || k_reg == fcount_reg) begin
                    if (bad_reg || g_reg == '0 || {1'b0, g_reg} >= prod_reg) begin
                        status_next = ST_BAD_ELEM;
                        acc_next    = 1'b0;
                        state_next  = S_FIN;
                    end else begin
                        phase_next = PH_G;
                        x_next     = g_reg;
                        k_next     = '0;
                        state_next = S_D0;
                    end
                end else if (f_cur < 13'd2 || f_cur > FACTOR_W'(MAX_ORDER) ||
                             prod_mul > (2*LEN_W)'(MAX_ORDER)) begin
                    bad_next = 1'b1;
                end else begin
                    prod_next = prod_mul[LEN_W-1:0];
                    k_next    = k_reg + 3'd1;
                end
            end
            S_D0: begin
                r_next      = div_r;
                q_next[11:6] = div_q;
                state_next  = S_D1;
            end
            S_D1: begin
                r_next      = div_r;
                q_next[5:0] = div_q;
                state_next  = S_ACC;
            end
            S_ACC: begin
                e1_next = e1_reg + term1[CODE_W-1:0];
                e2_next = e2_reg + term2[CODE_W-1:0];
                x_next  = q_reg;
                k_next  = k_reg + 3'd1;
                if (!last_factor) begin
                    state_next = S_D0;
                end else begin
                    unique case (phase_reg)
                        PH_G: begin
                            phase_next    = PH_SELF;
                            x_next        = '0;
                            k_next        = '0;
                            e1_next       = '0;
                            e2_next       = '0;
                            i_next        = '0;
                            cut_base_next = size_reg;
                            state_next    = S_D0;
                        end
                        PH_SELF: begin
                            sel_next   = 1'b0;
                            state_next = S_INS_RD;
                        end
                        default: begin
                            // Any sum that reaches zero rejects the whole add.
                            if (e1_next == '0 || e2_next == '0) begin
                                status_next = ST_ZERO;
                                acc_next    = 1'b0;
                                j_next      = cut_base_reg;
                                state_next  = S_CUT_RD;
                            end else begin
                                sel_next   = 1'b0;
                                state_next = S_INS_RD;
                            end
                        end
                    endcase
                end
            end
            S_INS_RD: begin
                state_next = S_INS_WR;
            end
            S_INS_WR: begin
                if (can_insert) begin
                    mem_we    = 1'b1;
                    mem_wa    = ins_val;
                    mem_wd    = 1'b1;
                    list_we   = 1'b1;
                    size_next = size_reg + 13'd1;
                end
                if (!sel_reg) begin
                    sel_next   = 1'b1;
                    state_next = S_INS_RD;
                end else begin
                    state_next = S_NEXT;
                end
            end
            S_NEXT: begin
                list_ra = i_reg[CODE_W-1:0];
                if (i_reg < cut_base_reg) begin
                    state_next = S_LOAD;
                end else begin
                    status_next = ST_OK;
                    acc_next    = 1'b1;
                    state_next  = S_FIN;
                end
            end
            S_LOAD: begin
                phase_next = PH_LIST;
                x_next     = list_q;
                k_next     = '0;
                e1_next    = '0;
                e2_next    = '0;
                i_next     = i_reg + 13'd1;
                state_next = S_D0;
            end
            S_CUT_RD: begin
                if (j_reg < size_reg) begin
                    state_next = S_CUT_WR;
                end else begin
                    size_next  = cut_base_reg;
                    state_next = S_FIN;
                end
            end
            S_CUT_WR: begin
                mem_we     = 1'b1;
                mem_wa     = list_q;
                j_next     = j_reg + 13'd1;
                state_next = S_CUT_RD;
            end
            S_FIN: begin
                if (fin_load) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_CLR;
            j_reg       <= '0;
            size_reg    <= '0;
            m_valid_reg <= 1'b0;
            fcount_reg  <= 3'd1;
            for (int n = 0; n < REG_FACTORS; n++) begin
                factor_reg[n] <= 13'd2;
            end
        end else begin
            state_reg <= state_next;
            j_reg     <= j_next;
            size_reg  <= size_next;
            if (fin_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (cfg_valid) begin
                if (cfg_index == CFG_FACTOR_COUNT) begin
                    fcount_reg <= cfg_data[INDEX_W-1:0];
                end else if (cfg_index <= INDEX_W'(REG_FACTORS)) begin
                    factor_reg[cfg_index - 3'd1] <= cfg_data;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        phase_reg    <= phase_next;
        k_reg        <= k_next;
        prod_reg     <= prod_next;
        bad_reg      <= bad_next;
        g_reg        <= g_next;
        x_reg        <= x_next;
        r_reg        <= r_next;
        q_reg        <= q_next;
        e1_reg       <= e1_next;
        e2_reg       <= e2_next;
        before_reg   <= before_next;
        i_reg        <= i_next;
        cut_base_reg <= cut_base_next;
        sel_reg      <= sel_next;
        status_reg   <= status_next;
        acc_reg      <= acc_next;
        if (state_reg == S_ORDER && !bad_reg && k_reg != fcount_reg &&
            k_reg < INDEX_W'(REG_FACTORS)) begin
            w_reg[k_reg] <= prod_reg;
        end
        if (state_reg == S_ACC && phase_reg == PH_G && k_reg < INDEX_W'(REG_FACTORS)) begin
            gd_reg[k_reg] <= r_reg[CODE_W-1:0];
        end
        if (fin_load) begin
            m_accepted_reg <= acc_reg;
            m_prev_reg     <= before_reg;
            m_len_reg      <= size_reg;
            m_status_reg   <= status_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            member_mem[mem_wa] <= mem_wd;
        end
        mem_q <= member_mem[mem_ra];
    end

    always_ff @(posedge aclk) begin
        if (list_we) begin
            list_mem[list_wa] <= list_wd;
        end
        list_q <= list_mem[list_ra];
    end

endmodule

[rtl/sssr_checker.sv]
module sssr_checker
    import sssr_pkg::*;
(
    input logic             aclk,
    input logic             aresetn,
    input logic             s_valid,
    input logic             s_ready,
    input logic             m_valid,
    input logic             m_ready,
    input logic             m_accepted,
    input logic [LEN_W-1:0] m_previous_length,
    input logic [LEN_W-1:0] m_reach_length,
    input logic [1:0]       m_status
);

    // A result that waits keeps its reach length and status.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_reach_length) && $stable(m_status))
        else $error("stalled result changed");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_accepted |-> m_status == ST_OK)
        else $error("accepted result with nonzero status");

    // Anything refused leaves the list length as it was.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_accepted |-> m_previous_length == m_reach_length)
        else $error("refused item changed the length");

    // An accepted item keeps the input closed on the following cycle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input still open after a beat");

    assert property (@(posedge aclk)
        !aresetn |=> !m_valid && !s_ready)
        else $error("activity right after reset");

endmodule

bind signed_subset_sum_reach_set_top sssr_checker u_sssr_checker (
    .aclk              (aclk),
    .aresetn           (aresetn),
    .s_valid           (s_valid),
    .s_ready           (s_ready),
    .m_valid           (m_valid),
    .m_ready           (m_ready),
    .m_accepted        (m_accepted),
    .m_previous_length (m_previous_length),
    .m_reach_length    (m_reach_length),
    .m_status          (m_status)
);
